// File: rtl/antialiased_glyph_column_renderer_unit_macros.svh
// ---------------------------------------------------------------------------
// antialiased glyph column renderer: assertion macros
// concurrent checks clocked on i_clk, with and without the reset guard
// ---------------------------------------------------------------------------
`ifndef ANTIALIASED_GLYPH_COLUMN_RENDERER_UNIT_MACROS_SVH
`define ANTIALIASED_GLYPH_COLUMN_RENDERER_UNIT_MACROS_SVH

// checked only while reset is released
`define AGCR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define AGCR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/agcr_pkg.sv
// ---------------------------------------------------------------------------
// agcr_pkg
// types, codes and the colour blend used by the glyph column renderer
// ---------------------------------------------------------------------------
package agcr_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_WIDTH = 2'd0,
        OP_LOAD_FONT  = 2'd1,
        OP_BEGIN_CHAR = 2'd2,
        OP_DRAW_COL   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_FG_COLOR     = 3'd0,
        CFG_BG_COLOR     = 3'd1,
        CFG_ORIGIN_X     = 3'd2,
        CFG_ORIGIN_Y     = 3'd3,
        CFG_FIRST_CHAR   = 3'd4,
        CFG_COLUMN_BYTES = 3'd5,
        CFG_RIGHT_TO_LEFT = 3'd6
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_WCNT,
        S_DCOL,
        S_DRD,
        S_DPIX
    } t_state;

    typedef logic [15:0] t_rgb565;
    typedef logic [3:0][15:0] t_palette;

    localparam logic [1:0] LVL_NONE = 2'd0;
    localparam logic [1:0] LVL_HALF = 2'd1;
    localparam logic [1:0] LVL_MOST = 2'd2;
    localparam logic [1:0] LVL_FULL = 2'd3;

    // 6554 / 65536 gives floor(x / 10) for x below 16000
    localparam logic [25:0] RECIP_TEN = 26'd6554;

    // bg + ratio * (fg - bg) / 100 truncated toward zero
    function automatic logic [7:0] blend_channel(input logic [7:0] bg,
                                                 input logic [7:0] fg,
                                                 input logic [1:0] lvl);
        logic signed [9:0] d;
        logic [8:0]        mag;
        logic [11:0]       m7;
        logic [25:0]       q;
        logic [7:0]        part;
        logic [7:0]        res;
        d    = $signed({2'b00, fg}) - $signed({2'b00, bg});
        mag  = d[9] ? 9'(-d) : 9'(d);
        m7   = 12'(mag) * 12'd7;
        q    = 26'(m7) * RECIP_TEN;
        part = 8'd0;
        res  = bg;
        unique case (lvl)
            LVL_NONE: res = bg;
            LVL_FULL: res = fg;
            LVL_HALF: begin
                part = 8'(mag >> 1);
                res  = d[9] ? bg - part : bg + part;
            end
            LVL_MOST: begin
                part = 8'(q >> 16);
                res  = d[9] ? bg - part : bg + part;
            end
            default: res = bg;
        endcase
        return res;
    endfunction

    function automatic t_rgb565 blend_rgb565(input logic [23:0] bg,
                                             input logic [23:0] fg,
                                             input logic [1:0] lvl);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = blend_channel(bg[23:16], fg[23:16], lvl);
        g = blend_channel(bg[15:8], fg[15:8], lvl);
        b = blend_channel(bg[7:0], fg[7:0], lvl);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

// File: rtl/agcr_palette.sv
// ---------------------------------------------------------------------------
// agcr_palette
// registered four-entry RGB565 palette, one colour per antialias level
// ---------------------------------------------------------------------------
module agcr_palette (
    input  logic                i_clk,
    input  logic [23:0]         i_fg,
    input  logic [23:0]         i_bg,
    output agcr_pkg::t_palette  o_pal
);

    agcr_pkg::t_palette r_pal;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_pal[k] <= agcr_pkg::blend_rgb565(i_bg, i_fg, 2'(k));
        end
    end

    assign o_pal = r_pal;

endmodule

// File: rtl/antialiased_glyph_column_renderer_unit.sv
// ---------------------------------------------------------------------------
// antialiased_glyph_column_renderer_unit
// 2 bpp column-major font renderer producing RGB565 pixels
// ---------------------------------------------------------------------------
// input items (s_axis): tuser carries the operation, tdata the operands.
//   load width / load font byte write the width table or font memory and
//   give no output.
//   begin character walks the width table from glyph 0 with one shared
//   multiply-add (width * column bytes), one entry per cycle.
//   draw column emits column_bytes * 4 pixels on m_axis, top to bottom, tlast
//   on the final one; a setup state, then per font byte one font memory read
//   and then four pixels.
// the block takes one item at a time; s_axis_tready is high only when idle.
// the output register holds a pixel until taken: a stall on m_axis_tready
// freezes the pixel loop, and an item may be accepted while the last pixel
// still waits.
// config writes (cfg channel) are always ready; registers change at the next
// edge and the colour palette follows in the cycle after.
// reset (i_rst_n low, synchronous) restores register defaults, clears the
// cursor and the column count; table and font contents are kept as they are.
// ---------------------------------------------------------------------------
module antialiased_glyph_column_renderer_unit #(
    parameter int GLYPH_COUNT      = 128,
    parameter int FONT_BYTES       = 8192,
    parameter int MAX_COLUMN_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // index[12:0], value[20:13], char_code[28:21], new_text[29], zero[31:30]
    input  logic [31:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_x[15:0], pixel_y[31:16], pixel_color[47:32]
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int GI_W = $clog2(GLYPH_COUNT);
    localparam int FA_W = $clog2(FONT_BYTES);
    localparam int B_W  = $clog2(MAX_COLUMN_BYTES + 1);

    // configuration
    logic [23:0] r_fg_color;
    logic [23:0] r_bg_color;
    logic [15:0] r_origin_x;
    logic [15:0] r_origin_y;
    logic [7:0]  r_first_char;
    logic [4:0]  r_column_bytes;
    logic        r_right_to_left;

    // memories
    logic [7:0] r_wmem [GLYPH_COUNT];
    logic [7:0] r_fmem [FONT_BYTES];
    logic [7:0] r_wrd;
    logic [7:0] r_frd;

    // sequencer state
    agcr_pkg::t_state r_state, n_state;
    logic [GI_W-1:0]  r_i, n_i;
    logic [GI_W-1:0]  r_chr, n_chr;
    logic             r_pend, n_pend;
    logic [15:0]      r_sum, n_sum;
    logic [GI_W-1:0]  r_glyph_index, n_glyph_index;
    logic [15:0]      r_glyph_base, n_glyph_base;
    logic [7:0]       r_ccount, n_ccount;
    logic [15:0]      r_cursor, n_cursor;
    logic [15:0]      r_colbase, n_colbase;
    logic [B_W-1:0]   r_b, n_b;
    logic [1:0]       r_p, n_p;
    logic             r_oob, n_oob;

    // output register
    logic             r_ovalid, n_ovalid;
    logic [15:0]      r_ox, n_ox;
    logic [15:0]      r_oy, n_oy;
    logic [15:0]      r_ocol, n_ocol;
    logic             r_olast, n_olast;

    agcr_pkg::t_palette w_pal;
    agcr_pkg::t_op      w_op;
    logic [12:0]        w_idx;
    logic [7:0]         w_val;
    logic [7:0]         w_code;
    logic               w_new_text;
    logic               w_accept;
    logic [4:0]         w_cb;
    logic [7:0]         w_chr8;
    logic               w_chr_ok;
    logic               w_wwe;
    logic               w_fwe;
    logic [GI_W-1:0]    w_wraddr;
    logic [15:0]        w_faddr;
    logic [7:0]         w_mul_a;
    logic [12:0]        w_mul_p;
    logic [7:0]         w_col;
    logic [1:0]         w_lvl;
    logic               w_last_byte;

    agcr_palette u_palette (
        .i_clk (i_clk),
        .i_fg  (r_fg_color),
        .i_bg  (r_bg_color),
        .o_pal (w_pal)
    );

    assign w_op       = agcr_pkg::t_op'(s_axis_tuser);
    assign w_idx      = s_axis_tdata[12:0];
    assign w_val      = s_axis_tdata[20:13];
    assign w_code     = s_axis_tdata[28:21];
    assign w_new_text = s_axis_tdata[29];

    assign s_axis_tready = (r_state == agcr_pkg::S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign w_cb = (r_column_bytes > 5'(MAX_COLUMN_BYTES)) ? 5'(MAX_COLUMN_BYTES)
                                                           : r_column_bytes;
    assign w_chr8   = w_code - r_first_char;
    assign w_chr_ok = ({1'b0, w_chr8} < 9'(GLYPH_COUNT));

    assign w_wwe = w_accept && (w_op == agcr_pkg::OP_LOAD_WIDTH)
                   && (w_idx < 13'(GLYPH_COUNT));
    assign w_fwe = w_accept && (w_op == agcr_pkg::OP_LOAD_FONT)
                   && (17'(w_idx) < 17'(FONT_BYTES));

    // width table is walked by r_i during a begin, else it serves the glyph
    assign w_wraddr = (r_state == agcr_pkg::S_WALK) ? r_i : r_glyph_index;
    assign w_faddr  = r_colbase + 16'(r_b);

    // shared multiplier: width * column bytes, or column number * column bytes
    assign w_mul_a = (r_state == agcr_pkg::S_DCOL) ? w_col : r_wrd;
    assign w_mul_p = 13'(w_mul_a) * 13'(w_cb);
    assign w_col   = r_right_to_left ? r_ccount - 8'd1 : r_wrd - r_ccount;

    assign w_lvl       = r_oob ? agcr_pkg::LVL_NONE : r_frd[{r_p, 1'b0} +: 2];
    assign w_last_byte = (5'(r_b) + 5'd1 == w_cb);

    always_ff @(posedge i_clk) begin
        if (w_wwe) begin
            r_wmem[w_idx[GI_W-1:0]] <= w_val;
        end
        r_wrd <= r_wmem[w_wraddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_fwe) begin
            r_fmem[FA_W'(w_idx)] <= w_val;
        end
        r_frd <= r_fmem[w_faddr[FA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_color      <= 24'hFFFFFF;
            r_bg_color      <= 24'h000000;
            r_origin_x      <= 16'd0;
            r_origin_y      <= 16'd0;
            r_first_char    <= 8'd32;
            r_column_bytes  <= 5'd2;
            r_right_to_left <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (agcr_pkg::t_cfg_reg'(i_cfg_index))
                agcr_pkg::CFG_FG_COLOR:      r_fg_color      <= i_cfg_data;
                agcr_pkg::CFG_BG_COLOR:      r_bg_color      <= i_cfg_data;
                agcr_pkg::CFG_ORIGIN_X:      r_origin_x      <= i_cfg_data[15:0];
                agcr_pkg::CFG_ORIGIN_Y:      r_origin_y      <= i_cfg_data[15:0];
                agcr_pkg::CFG_FIRST_CHAR:    r_first_char    <= i_cfg_data[7:0];
                agcr_pkg::CFG_COLUMN_BYTES:  r_column_bytes  <= i_cfg_data[4:0];
                agcr_pkg::CFG_RIGHT_TO_LEFT: r_right_to_left <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= agcr_pkg::S_IDLE;
            r_glyph_index <= '0;
            r_glyph_base  <= 16'd0;
            r_ccount      <= 8'd0;
            r_cursor      <= 16'd0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_glyph_index <= n_glyph_index;
            r_glyph_base  <= n_glyph_base;
            r_ccount      <= n_ccount;
            r_cursor      <= n_cursor;
            r_ovalid      <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_chr     <= n_chr;
        r_pend    <= n_pend;
        r_sum     <= n_sum;
        r_colbase <= n_colbase;
        r_b       <= n_b;
        r_p       <= n_p;
        r_oob     <= n_oob;
        r_ox      <= n_ox;
        r_oy      <= n_oy;
        r_ocol    <= n_ocol;
        r_olast   <= n_olast;
    end

    always_comb begin
        n_state       = r_state;
        n_i           = r_i;
        n_chr         = r_chr;
        n_pend        = r_pend;
        n_sum         = r_sum;
        n_glyph_index = r_glyph_index;
        n_glyph_base  = r_glyph_base;
        n_ccount      = r_ccount;
        n_cursor      = r_cursor;
        n_colbase     = r_colbase;
        n_b           = r_b;
        n_p           = r_p;
        n_oob         = r_oob;
        n_ovalid      = r_ovalid && !m_axis_tready;
        n_ox          = r_ox;
        n_oy          = r_oy;
        n_ocol        = r_ocol;
        n_olast       = r_olast;

        unique case (r_state)
            agcr_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        agcr_pkg::OP_BEGIN_CHAR: begin
                            if (w_new_text) begin
                                n_cursor = 16'd0;
                            end
                            if (w_chr_ok) begin
                                n_chr   = w_chr8[GI_W-1:0];
                                n_i     = '0;
                                n_sum   = 16'd0;
                                n_pend  = 1'b0;
                                n_state = agcr_pkg::S_WALK;
                            end else begin
                                n_ccount = 8'd0;
                            end
                        end
                        agcr_pkg::OP_DRAW_COL: begin
                            if (r_ccount != 8'd0) begin
                                n_state = agcr_pkg::S_DCOL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            agcr_pkg::S_WALK: begin
                if (r_pend) begin
                    n_sum = r_sum + 16'(w_mul_p);
                end
                if (r_i != r_chr) begin
                    n_i    = r_i + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    // this read fetches the glyph's own width
                    n_pend  = 1'b0;
                    n_state = agcr_pkg::S_WCNT;
                end
            end
            agcr_pkg::S_WCNT: begin
                n_ccount      = r_wrd;
                n_glyph_index = r_chr;
                n_glyph_base  = r_sum;
                n_state       = agcr_pkg::S_IDLE;
            end
            agcr_pkg::S_DCOL: begin
                n_colbase = r_glyph_base + 16'(w_mul_p);
                n_b       = '0;
                if (w_cb == 5'd0) begin
                    n_cursor = r_right_to_left ? r_cursor - 16'd1 : r_cursor + 16'd1;
                    n_ccount = r_ccount - 8'd1;
                    n_state  = agcr_pkg::S_IDLE;
                end else begin
                    n_state = agcr_pkg::S_DRD;
                end
            end
            agcr_pkg::S_DRD: begin
                n_oob   = ({1'b0, w_faddr} >= 17'(FONT_BYTES));
                n_p     = 2'd0;
                n_state = agcr_pkg::S_DPIX;
            end
            agcr_pkg::S_DPIX: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_ox     = r_origin_x + r_cursor;
                    n_oy     = r_origin_y + 16'({r_b, 2'b00}) + 16'(r_p);
                    n_ocol   = w_pal[w_lvl];
                    n_olast  = w_last_byte && (r_p == 2'd3);
                    if (r_p == 2'd3) begin
                        if (w_last_byte) begin
                            n_cursor = r_right_to_left ? r_cursor - 16'd1
                                                       : r_cursor + 16'd1;
                            n_ccount = r_ccount - 8'd1;
                            n_state  = agcr_pkg::S_IDLE;
                        end else begin
                            n_b     = r_b + 1'b1;
                            n_state = agcr_pkg::S_DRD;
                        end
                    end else begin
                        n_p = r_p + 2'd1;
                    end
                end
            end
            default: n_state = agcr_pkg::S_IDLE;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_ocol, r_oy, r_ox};
    assign m_axis_tlast  = r_olast;

endmodule

// File: rtl/agcr_checker.sv
// ---------------------------------------------------------------------------
// agcr_checker
// port-level checks on the glyph column renderer, bound to the top level
// ---------------------------------------------------------------------------
`include "antialiased_glyph_column_renderer_unit_macros.svh"

module agcr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled pixel keeps its position, colour and end marker
    `AGCR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output item changed under stall")

    // a waiting input item is held until taken
    `AGCR_ASSERT(a_in_hold, s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser), "input item changed while waiting")

    // no pixel is shown in the cycle after reset
    `AGCR_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

    // loads and begin character never produce a pixel
    `AGCR_ASSERT(a_no_pixel_non_draw, s_axis_tvalid && s_axis_tready && !m_axis_tvalid && (s_axis_tuser != agcr_pkg::OP_DRAW_COL) |=> !m_axis_tvalid, "pixel from a non-draw item")

endmodule

bind antialiased_glyph_column_renderer_unit agcr_checker u_agcr_checker (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// glyph column renderer testbench
// drives load, begin-character and draw-column items over the input stream,
// predicts every pixel of every column from the font and colour settings and
// checks each output item in order, under random idling on both sides
// ---------------------------------------------------------------------------
module testbench;

    localparam int GLYPHS   = 128;
    localparam int FONT_SZ  = 8192;
    localparam int CB_MAX   = 16;
    localparam int WD_LIMIT = 4000;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] color;
        logic        last;
    } t_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    antialiased_glyph_column_renderer_unit u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted renderer state
    logic [23:0] fg_rgb = 24'hFFFFFF, bg_rgb = '0;
    logic [15:0] org_x = '0, org_y = '0;
    logic [7:0]  first_code = 8'd32;
    logic [4:0]  col_bytes = 5'd2;
    logic        mirror = 1'b0;
    logic [7:0]  widths [GLYPHS];
    logic [7:0]  font [FONT_SZ];
    bit          width_known [GLYPHS];
    bit          font_known [FONT_SZ];
    logic [6:0]  cur_glyph = '0;
    logic [15:0] cur_base = '0;
    logic [7:0]  cols_left = '0;
    logic [15:0] cursor = '0;

    t_pixel pixel_q[$];
    int     errors = 0;
    int     idle_cnt = 0;
    int     send_idle = 0;
    int     recv_idle = 0;
    int     n_sent = 0;

    function automatic int unsigned eff_cb();
        return (col_bytes > CB_MAX) ? CB_MAX : 32'(col_bytes);
    endfunction

    function automatic logic [7:0] blend(logic [7:0] bg, logic [7:0] fg, int ratio);
        int d;
        d = ratio * (int'(fg) - int'(bg));
        return 8'(int'(bg) + d / 100);
    endfunction

    function automatic logic [15:0] shade(logic [1:0] lvl);
        int ratio;
        logic [7:0] r, g, b;
        case (lvl)
            agcr_pkg::LVL_NONE: ratio = 0;
            agcr_pkg::LVL_HALF: ratio = 50;
            agcr_pkg::LVL_MOST: ratio = 70;
            default:            ratio = 100;
        endcase
        r = blend(bg_rgb[23:16], fg_rgb[23:16], ratio);
        g = blend(bg_rgb[15:8], fg_rgb[15:8], ratio);
        b = blend(bg_rgb[7:0], fg_rgb[7:0], ratio);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    // font address of byte b of the column about to be drawn
    function automatic int unsigned column_addr(int unsigned b);
        int unsigned col;
        col = mirror ? (cols_left - 1) & 8'hFF : (widths[cur_glyph] - cols_left) & 8'hFF;
        return (cur_base + eff_cb() * col + b) & 16'hFFFF;
    endfunction

    task automatic predict(agcr_pkg::t_op op, logic [12:0] idx, logic [7:0] val,
                           logic [7:0] code, logic fresh);
        int unsigned chr, sum, cb, addr;
        logic [7:0] fb;
        t_pixel px;
        cb = eff_cb();
        case (op)
            agcr_pkg::OP_LOAD_WIDTH: if (idx < GLYPHS) begin
                widths[idx] = val;
                width_known[idx] = 1;
            end
            agcr_pkg::OP_LOAD_FONT: begin
                font[idx] = val;
                font_known[idx] = 1;
            end
            agcr_pkg::OP_BEGIN_CHAR: begin
                chr = 32'(8'(code - first_code));
                if (fresh) cursor = '0;
                if (chr < GLYPHS) begin
                    sum = 0;
                    for (int i = 0; i < chr; i++) sum = (sum + widths[i] * cb) & 16'hFFFF;
                    cur_glyph = 7'(chr);
                    cur_base = 16'(sum);
                    cols_left = widths[chr];
                end else begin
                    cols_left = '0;
                end
            end
            default: if (cols_left != 0) begin
                for (int unsigned b = 0; b < cb; b++) begin
                    addr = column_addr(b);
                    fb = (addr < FONT_SZ) ? font[addr] : 8'h00;
                    for (int unsigned p = 0; p < 4; p++) begin
                        px.x = org_x + cursor;
                        px.y = org_y + 16'(4 * b + p);
                        px.color = shade(fb[2*p +: 2]);
                        px.last = (b + 1 == cb) && (p == 3);
                        pixel_q.push_back(px);
                    end
                end
                cursor = mirror ? cursor - 1'b1 : cursor + 1'b1;
                cols_left--;
            end
        endcase
    endtask

    task automatic send_item(agcr_pkg::t_op op, logic [12:0] idx, logic [7:0] val,
                             logic [7:0] code, logic fresh);
        while ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, fresh, code, val, idx};
        predict(op, idx, val, code, fresh);
        n_sent++;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // fills in any table entry or font byte the item would read before it is sent
    task automatic render_item(agcr_pkg::t_op op, logic [12:0] idx, logic [7:0] val,
                               logic [7:0] code, logic fresh);
        int unsigned chr, addr;
        if (op == agcr_pkg::OP_BEGIN_CHAR) begin
            chr = 32'(8'(code - first_code));
            if (chr < GLYPHS)
                for (int i = 0; i <= chr; i++)
                    if (!width_known[i])
                        send_item(agcr_pkg::OP_LOAD_WIDTH, 13'(i),
                                  8'($urandom_range(0, 4)), '0, 0);
        end else if (op == agcr_pkg::OP_DRAW_COL && cols_left != 0) begin
            for (int unsigned b = 0; b < eff_cb(); b++) begin
                addr = column_addr(b);
                if (addr < FONT_SZ && !font_known[addr])
                    send_item(agcr_pkg::OP_LOAD_FONT, 13'(addr), 8'($urandom), '0, 0);
            end
        end
        send_item(op, idx, val, code, fresh);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_reg(agcr_pkg::t_cfg_reg r, logic [23:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (r)
            agcr_pkg::CFG_FG_COLOR:     fg_rgb = d;
            agcr_pkg::CFG_BG_COLOR:     bg_rgb = d;
            agcr_pkg::CFG_ORIGIN_X:     org_x = d[15:0];
            agcr_pkg::CFG_ORIGIN_Y:     org_y = d[15:0];
            agcr_pkg::CFG_FIRST_CHAR:   first_code = d[7:0];
            agcr_pkg::CFG_COLUMN_BYTES: col_bytes = d[4:0];
            default:                    mirror = d[0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic setup(logic [23:0] fg, logic [23:0] bg, logic [15:0] ox,
                         logic [15:0] oy, logic [7:0] fc, logic [4:0] cb, logic rtl);
        drain();
        write_reg(agcr_pkg::CFG_FG_COLOR, fg);
        write_reg(agcr_pkg::CFG_BG_COLOR, bg);
        write_reg(agcr_pkg::CFG_ORIGIN_X, 24'(ox));
        write_reg(agcr_pkg::CFG_ORIGIN_Y, 24'(oy));
        write_reg(agcr_pkg::CFG_FIRST_CHAR, 24'(fc));
        write_reg(agcr_pkg::CFG_COLUMN_BYTES, 24'(cb));
        write_reg(agcr_pkg::CFG_RIGHT_TO_LEFT, 24'(rtl));
    endtask

    task automatic test_directed();
        send_item(agcr_pkg::OP_LOAD_WIDTH, 13'd0, 8'd1, '0, 0);
        send_item(agcr_pkg::OP_LOAD_WIDTH, 13'd1, 8'd2, '0, 0);
        send_item(agcr_pkg::OP_LOAD_WIDTH, 13'd2, 8'd0, '0, 0);
        send_item(agcr_pkg::OP_LOAD_WIDTH, 13'd3, 8'd3, '0, 0);
        send_item(agcr_pkg::OP_LOAD_WIDTH, 13'd8191, 8'd255, '0, 0);   // index past the table
        send_item(agcr_pkg::OP_LOAD_FONT, 13'd0, 8'h00, '0, 0);
        send_item(agcr_pkg::OP_LOAD_FONT, 13'd1, 8'hFF, '0, 0);
        send_item(agcr_pkg::OP_LOAD_FONT, 13'd2, 8'hE4, '0, 0);
        send_item(agcr_pkg::OP_LOAD_FONT, 13'd3, 8'h1B, '0, 0);
        send_item(agcr_pkg::OP_LOAD_FONT, 13'd8191, 8'hA5, 8'hFF, 1);
        render_item(agcr_pkg::OP_BEGIN_CHAR, '0, '0, 8'd32, 1);
        render_item(agcr_pkg::OP_DRAW_COL, '0, '0, '0, 0);
        render_item(agcr_pkg::OP_DRAW_COL, '0, '0, '0, 0);               // nothing left
        render_item(agcr_pkg::OP_BEGIN_CHAR, '0, '0, 8'd33, 0);
        render_item(agcr_pkg::OP_DRAW_COL, '0, '0, '0, 0);
        render_item(agcr_pkg::OP_DRAW_COL, '0, '0, '0, 0);
        render_item(agcr_pkg::OP_BEGIN_CHAR, '0, '0, 8'd34, 0);          // zero-width glyph
        render_item(agcr_pkg::OP_DRAW_COL, '0, '0, '0, 0);
        render_item(agcr_pkg::OP_BEGIN_CHAR, 13'h1FFF, 8'hFF, 8'd31, 1); // below the font
        render_item(agcr_pkg::OP_DRAW_COL, 13'h1FFF, 8'hFF, 8'hFF, 1);
        render_item(agcr_pkg::OP_BEGIN_CHAR, '0, '0, 8'd35, 1);
        render_item(agcr_pkg::OP_DRAW_COL, '0, '0, '0, 0);
        send_item(agcr_pkg::OP_LOAD_WIDTH, 13'd3, 8'd1, '0, 0);          // width changed mid-glyph
        render_item(agcr_pkg::OP_DRAW_COL, '0, '0, '0, 0);
        render_item(agcr_pkg::OP_DRAW_COL, '0, '0, '0, 0);
    endtask

    // n counts every item sent, the fill-in loads included
    task automatic test_random(int n);
        int start, r;
        start = n_sent;
        while (n_sent - start < n) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
                render_item(agcr_pkg::OP_BEGIN_CHAR, 13'($urandom), 8'($urandom),
                            first_code + 8'($urandom_range(0, 12)), 1'($urandom));
                repeat ($urandom_range(1, 4)) begin
                    render_item(agcr_pkg::OP_DRAW_COL, 13'($urandom), 8'($urandom),
                                8'($urandom), 1'($urandom));
                end
            end else begin
                render_item(agcr_pkg::t_op'(r - 6), 13'($urandom), 8'($urandom),
                            8'($urandom), 1'($urandom));
            end
        end
    endtask

    // output check and watchdog
    always @(posedge i_clk) begin
        t_pixel got, want;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WD_LIMIT) begin
                $display("[antialiased_glyph_column_renderer_unit] ERROR");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                       m_axis_tlast};
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected pixel, exp none got %h", $time, got);
                    errors++;
                end else begin
                    want = pixel_q.pop_front();
                    if (got.x !== want.x)
                        $display("%0t: x exp %h got %h", $time, want.x, got.x);
                    if (got.y !== want.y)
                        $display("%0t: y exp %h got %h", $time, want.y, got.y);
                    if (got.color !== want.color)
                        $display("%0t: color exp %h got %h", $time, want.color, got.color);
                    if (got.last !== want.last)
                        $display("%0t: last exp %b got %b", $time, want.last, got.last);
                    if (got !== want) errors++;
                end
            end
        end
    end

    always @(posedge i_clk) m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle = 6;
        recv_idle = 56;
        test_directed();
        setup(24'($urandom), 24'($urandom), 16'hFFFE, 16'hFFF0, 8'd0, 5'd1, 1'b1);
        test_random(35);
        setup(24'h000000, 24'hFFFFFF, 16'($urandom), 16'($urandom), 8'd255, 5'd0, 1'b0);
        test_random(15);
        send_idle = 56;
        recv_idle = 6;
        setup(24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
              8'($urandom), 5'd31, 1'b0);
        test_random(40);
        setup(24'($urandom), 24'($urandom), 16'hFFFF, 16'($urandom), 8'd32, 5'd16, 1'b1);
        test_random(40);
        send_idle = 0;
        recv_idle = 0;
        setup(24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
              8'($urandom_range(20, 60)), 5'($urandom_range(1, 4)), 1'($urandom));
        test_random(65);
        drain();
        if (errors == 0 && pixel_q.size() == 0)
            $display("[antialiased_glyph_column_renderer_unit] OK");
        else
            $display("[antialiased_glyph_column_renderer_unit] ERROR");
        $finish;
    end
endmodule
